// ----- sv/cal_pkg.sv -----
// Shared constants, operation and status codes, and the cell control struct.
package cal_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [3:0] OP_APPEND = 4'd0;
	localparam logic [3:0] OP_INSERT = 4'd1;
	localparam logic [3:0] OP_ERASE  = 4'd2;
	localparam logic [3:0] OP_SET    = 4'd3;
	localparam logic [3:0] OP_BEGIN  = 4'd4;
	localparam logic [3:0] OP_END    = 4'd5;
	localparam logic [3:0] OP_PREV   = 4'd6;
	localparam logic [3:0] OP_NEXT   = 4'd7;
	localparam logic [3:0] OP_CLEAR  = 4'd8;
	localparam logic [3:0] OP_FIND   = 4'd9;
	localparam logic [3:0] OP_READ   = 4'd10;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic              capture;
		logic              do_append;
		logic              do_insert;
		logic              do_erase;
		logic [IDX_W-1:0]  cursor;
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] value;
	} cal_ctrl_t;

endpackage

// ----- sv/cursor_array_list.sv -----
// Top level of the cursor list: cursor and size control around a chain of slot cells.
//
// Bounded ordered list of up to 16 entries of 32 bits with a cursor. Pulse
// start with an operation while busy is low; the item is accepted at that
// edge. Every item returns exactly one result: done is high for one cycle
// with read_value, found_index, cursor_now, list_size and status valid in
// that same cycle. The receiver cannot stall, so capture the result
// whenever done is high. busy is high in the cycle after each accept, so the
// block cannot take a new item before the last one is through; that cycle is
// spent resolving the first matching slot from the match flags that every
// cell registers at accept. Insert and erase shift the slots from the cursor
// up together at accept, each cell taking its neighbor's entry. Entries never
// written read back as anything, but only entries below list_size are ever returned.
module cursor_array_list (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [3:0]                 operation,
	input  logic [cal_pkg::DATA_W-1:0] value,
	input  logic [cal_pkg::IDX_W-1:0]  position,
	output logic                       done,
	output logic [cal_pkg::DATA_W-1:0] read_value,
	output logic [cal_pkg::IDX_W-1:0]  found_index,
	output logic [cal_pkg::IDX_W-1:0]  cursor_now,
	output logic [cal_pkg::CNT_W-1:0]  list_size,
	output logic [2:0]                 status
);

	localparam int N = cal_pkg::CAPACITY;

	logic                       accept;
	logic [cal_pkg::CNT_W-1:0]  count_q;
	logic [cal_pkg::IDX_W-1:0]  cursor_q;
	logic                       empty;
	logic                       full;
	logic [cal_pkg::CNT_W-1:0]  cnt_dec;
	logic [cal_pkg::CNT_W-1:0]  cur_c;

	// next state of the control registers, decided at accept
	logic [cal_pkg::CNT_W-1:0]  count_d;
	logic [cal_pkg::IDX_W-1:0]  cursor_d;
	logic [2:0]                 st_d;
	logic                       take_rd;
	cal_pkg::cal_ctrl_t         ctrl;

	// first stage: status and read data of the accepted item
	logic                       valid_s1;
	logic                       find_s1;
	logic [2:0]                 st_s1;
	logic [cal_pkg::DATA_W-1:0] rd_s1;

	logic [cal_pkg::DATA_W-1:0] cell_data [N];
	logic [N-1:0]               prior;
	logic [N-1:0]               first;
	logic [cal_pkg::IDX_W-1:0]  hit_idx;
	logic                       hit_any;

	assign accept  = start & ~busy;
	assign busy    = valid_s1;
	assign empty   = (count_q == '0);
	assign full    = (count_q == cal_pkg::CNT_W'(N));
	assign cnt_dec = count_q - cal_pkg::CNT_W'(1);
	assign cur_c   = cal_pkg::CNT_W'(cursor_q);

	always_comb begin
		count_d  = count_q;
		cursor_d = cursor_q;
		st_d     = cal_pkg::ST_OK;
		take_rd  = 1'b0;
		ctrl.do_append = 1'b0;
		ctrl.do_insert = 1'b0;
		ctrl.do_erase  = 1'b0;
		case (operation)
			cal_pkg::OP_APPEND, cal_pkg::OP_INSERT: begin
				if (full) begin
					st_d = cal_pkg::ST_FULL;
				end else begin
					count_d        = count_q + cal_pkg::CNT_W'(1);
					ctrl.do_append = (operation == cal_pkg::OP_APPEND);
					ctrl.do_insert = (operation == cal_pkg::OP_INSERT);
				end
			end
			cal_pkg::OP_ERASE: begin
				if (empty) begin
					st_d = cal_pkg::ST_EMPTY;
				end else begin
					count_d       = cnt_dec;
					take_rd       = 1'b1;
					ctrl.do_erase = 1'b1;
					// pull the cursor back when the last entry goes away
					if (cnt_dec == '0) begin
						cursor_d = '0;
					end else if (cur_c >= cnt_dec) begin
						cursor_d = cal_pkg::IDX_W'(cnt_dec - cal_pkg::CNT_W'(1));
					end
				end
			end
			cal_pkg::OP_SET: begin
				if (empty) begin
					st_d = cal_pkg::ST_EMPTY;
				end else if (cal_pkg::CNT_W'(position) >= count_q) begin
					st_d = cal_pkg::ST_RANGE;
				end else begin
					cursor_d = position;
				end
			end
			cal_pkg::OP_BEGIN: begin
				cursor_d = '0;
				if (empty) begin
					st_d = cal_pkg::ST_EMPTY;
				end
			end
			cal_pkg::OP_END: begin
				if (empty) begin
					cursor_d = '0;
					st_d     = cal_pkg::ST_EMPTY;
				end else begin
					cursor_d = cal_pkg::IDX_W'(cnt_dec);
				end
			end
			cal_pkg::OP_PREV: begin
				if (empty) begin
					st_d = cal_pkg::ST_EMPTY;
				end else if (cursor_q != '0) begin
					cursor_d = cursor_q - cal_pkg::IDX_W'(1);
				end
			end
			cal_pkg::OP_NEXT: begin
				if (empty) begin
					st_d = cal_pkg::ST_EMPTY;
				end else if (cur_c + cal_pkg::CNT_W'(1) < count_q) begin
					cursor_d = cursor_q + cal_pkg::IDX_W'(1);
				end
			end
			cal_pkg::OP_CLEAR: begin
				count_d  = '0;
				cursor_d = '0;
			end
			cal_pkg::OP_FIND, cal_pkg::OP_READ: begin
				if (empty) begin
					st_d = cal_pkg::ST_EMPTY;
				end else begin
					take_rd = (operation == cal_pkg::OP_READ);
				end
			end
			default: begin
			end
		endcase
		// only act on the cells when the item is really taken
		ctrl.do_append = ctrl.do_append & accept;
		ctrl.do_insert = ctrl.do_insert & accept;
		ctrl.do_erase  = ctrl.do_erase & accept;
		ctrl.capture   = accept;
		ctrl.cursor    = cursor_q;
		ctrl.count     = count_q;
		ctrl.value     = value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			valid_s1 <= 1'b0;
			find_s1  <= 1'b0;
			st_s1    <= cal_pkg::ST_OK;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				count_q  <= count_d;
				cursor_q <= cursor_d;
				st_s1    <= st_d;
				find_s1  <= (operation == cal_pkg::OP_FIND) && !empty;
			end
		end
	end

	// hold the entry under the cursor before any shift moves it
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= take_rd ? cell_data[cursor_q] : '0;
		end
	end

	// the slot chain; each cell sees both neighbors and passes the match prefix up
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [cal_pkg::DATA_W-1:0] left_w;
		logic [cal_pkg::DATA_W-1:0] right_w;
		logic                       prior_w;

		if (i == 0) begin : g_lo
			assign left_w  = value;
			assign prior_w = 1'b0;
		end else begin : g_mid
			assign left_w  = cell_data[i-1];
			assign prior_w = prior[i-1];
		end
		if (i == N - 1) begin : g_hi
			assign right_w = '0;
		end else begin : g_up
			assign right_w = cell_data[i+1];
		end

		cal_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (cal_pkg::IDX_W'(i)),
			.ctrl       (ctrl),
			.left_data  (left_w),
			.right_data (right_w),
			.prior_in   (prior_w),
			.data       (cell_data[i]),
			.prior_out  (prior[i]),
			.first      (first[i])
		);
	end

	// only one cell can flag first, so OR its index together
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (first[i]) begin
				hit_idx = hit_idx | cal_pkg::IDX_W'(i);
			end
		end
	end
	assign hit_any = prior[N-1];

	// drive done high for one cycle per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_value  <= rd_s1;
			cursor_now  <= cursor_q;
			list_size   <= count_q;
			found_index <= (find_s1 && hit_any) ? hit_idx : '0;
			if (find_s1) begin
				status <= hit_any ? cal_pkg::ST_OK : cal_pkg::ST_NOTFOUND;
			end else begin
				status <= st_s1;
			end
		end
	end

endmodule

// ----- sv/cal_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors, and flags a first match.
module cal_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cal_pkg::IDX_W-1:0]  idx,
	input  cal_pkg::cal_ctrl_t         ctrl,
	input  logic [cal_pkg::DATA_W-1:0] left_data,
	input  logic [cal_pkg::DATA_W-1:0] right_data,
	input  logic                       prior_in,
	output logic [cal_pkg::DATA_W-1:0] data,
	output logic                       prior_out,
	output logic                       first
);

	logic [cal_pkg::DATA_W-1:0] data_q;
	logic                       match_q;
	logic [cal_pkg::CNT_W-1:0]  idx_c;
	logic [cal_pkg::CNT_W-1:0]  idx_p1;
	logic [cal_pkg::CNT_W-1:0]  cur_c;

	assign idx_c  = cal_pkg::CNT_W'(idx);
	assign idx_p1 = idx_c + cal_pkg::CNT_W'(1);
	assign cur_c  = cal_pkg::CNT_W'(ctrl.cursor);

	// entry storage: append writes the slot at the end, insert opens a gap at
	// the cursor, erase closes the gap at the cursor
	always_ff @(posedge clk) begin
		if (ctrl.do_append && idx_c == ctrl.count) begin
			data_q <= ctrl.value;
		end else if (ctrl.do_insert && idx == ctrl.cursor) begin
			data_q <= ctrl.value;
		end else if (ctrl.do_insert && idx_c > cur_c && idx_c <= ctrl.count) begin
			data_q <= left_data;
		end else if (ctrl.do_erase && idx_c >= cur_c && idx_p1 < ctrl.count) begin
			data_q <= right_data;
		end
	end

	// compare against the search value of every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.capture) begin
			match_q <= (data_q == ctrl.value) && (idx_c < ctrl.count);
		end
	end

	assign data      = data_q;
	assign prior_out = prior_in | match_q;
	assign first     = match_q & ~prior_in;

endmodule

// ----- bench/tb_cursor_array_list.sv -----
// Self-checking testbench for the cursor list: directed table, then random items.
module tb_cursor_array_list;

	// Operation codes the block leaves unused; they must report state and change nothing.
	localparam logic [3:0] OP_SPARE_LO = 4'd11;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	// Cycles with neither an accepted item nor a result before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles to linger after the last result, to catch a stray extra strobe.
	localparam int TAIL_CYCLES = 4;

	// One result item, laid out in port order so it packs straight from the outputs.
	typedef struct packed {
		logic [cal_pkg::DATA_W-1:0] read_val;
		logic [cal_pkg::IDX_W-1:0]  match_idx;
		logic [cal_pkg::IDX_W-1:0]  cur_pos;
		logic [cal_pkg::CNT_W-1:0]  entries_held;
		logic [2:0]                 code;
	} list_result_t;

	// One row of the directed script. Rows with known set carry a hand-typed result;
	// the rest are checked against the list model below.
	typedef struct packed {
		logic [3:0]                 op;
		logic [cal_pkg::DATA_W-1:0] val;
		logic [cal_pkg::IDX_W-1:0]  pos;
		logic [4:0]                 reps;
		logic                       known;
		list_result_t               res;
	} script_row_t;

	function automatic script_row_t row_of(input logic [3:0] op,
			input logic [cal_pkg::DATA_W-1:0] val, input logic [cal_pkg::IDX_W-1:0] pos,
			input logic [4:0] reps, input logic known,
			input logic [cal_pkg::DATA_W-1:0] rd, input logic [cal_pkg::IDX_W-1:0] fidx,
			input logic [cal_pkg::IDX_W-1:0] cur, input logic [cal_pkg::CNT_W-1:0] held,
			input logic [2:0] code);
		script_row_t r;
		r.op = op;
		r.val = val;
		r.pos = pos;
		r.reps = reps;
		r.known = known;
		r.res = {rd, fidx, cur, held, code};
		return r;
	endfunction

	localparam int SCRIPT_LEN = 26;

	// Walk the empty-list cases first, then build a two-entry list, fill it to the
	// brim, hit the full-list rejects, erase the last entry, clear, and reuse.
	script_row_t script [SCRIPT_LEN] = '{
		row_of(cal_pkg::OP_READ,   32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_EMPTY),
		row_of(cal_pkg::OP_ERASE,  32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_EMPTY),
		row_of(cal_pkg::OP_SET,    32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_EMPTY),
		row_of(cal_pkg::OP_BEGIN,  32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_EMPTY),
		row_of(cal_pkg::OP_END,    32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_EMPTY),
		row_of(cal_pkg::OP_PREV,   32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_EMPTY),
		row_of(cal_pkg::OP_NEXT,   32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_EMPTY),
		row_of(cal_pkg::OP_FIND,   32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_EMPTY),
		row_of(cal_pkg::OP_APPEND, 32'hFFFFFFFF, 4'd15, 5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd1,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_INSERT, 32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd2,  cal_pkg::ST_OK),
		row_of(OP_SPARE_HI,        32'hFFFFFFFF, 4'd15, 5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd2,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_FIND,   32'hFFFFFFFF, 4'd0,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_FIND,   32'h12345678, 4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd2,  cal_pkg::ST_NOTFOUND),
		row_of(cal_pkg::OP_SET,    32'h0,        4'd15, 5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd2,  cal_pkg::ST_RANGE),
		row_of(cal_pkg::OP_SET,    32'h0,        4'd1,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_NEXT,   32'h0,        4'd0,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_PREV,   32'h0,        4'd0,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_PREV,   32'h0,        4'd0,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_APPEND, 32'hA5A5A5A5, 4'd0,  5'd14, 1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_APPEND, 32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd16, cal_pkg::ST_FULL),
		row_of(cal_pkg::OP_INSERT, 32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd16, cal_pkg::ST_FULL),
		row_of(cal_pkg::OP_END,    32'h0,        4'd0,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_ERASE,  32'h0,        4'd0,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_CLEAR,  32'h0,        4'd0,  5'd1,  1'b1,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_INSERT, 32'h5A5A5A5A, 4'd0,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK),
		row_of(cal_pkg::OP_ERASE,  32'h0,        4'd0,  5'd1,  1'b0,
			32'h0, 4'd0, 4'd0, 5'd0,  cal_pkg::ST_OK)
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic [3:0]                 operation = cal_pkg::OP_READ;
	logic [cal_pkg::DATA_W-1:0] value = '0;
	logic [cal_pkg::IDX_W-1:0]  position = '0;
	logic                       busy;
	logic                       done;
	logic [cal_pkg::DATA_W-1:0] read_value;
	logic [cal_pkg::IDX_W-1:0]  found_index;
	logic [cal_pkg::IDX_W-1:0]  cursor_now;
	logic [cal_pkg::CNT_W-1:0]  list_size;
	logic [2:0]                 status;

	// Hand-typed result riding along with the item being offered.
	logic                       known_valid = 1'b0;
	list_result_t               known_result = '0;

	// Model of the list: entries, fill count and cursor.
	logic [cal_pkg::DATA_W-1:0] slot_mem [cal_pkg::CAPACITY];
	logic [cal_pkg::CNT_W-1:0]  held_count = '0;
	logic [cal_pkg::IDX_W-1:0]  cursor_pos = '0;

	// Results owed by the block, oldest first.
	list_result_t               pending_results [$];

	// Recently stored values, so that searches hit as well as miss.
	logic [cal_pkg::DATA_W-1:0] value_pool [8];

	int                         fail_count = 0;
	int                         idle_cycles = 0;

	cursor_array_list uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.value       (value),
		.position    (position),
		.done        (done),
		.read_value  (read_value),
		.found_index (found_index),
		.cursor_now  (cursor_now),
		.list_size   (list_size),
		.status      (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one operation to the model and return the result the block owes for it.
	function automatic list_result_t apply_list_op(input logic [3:0] op,
			input logic [cal_pkg::DATA_W-1:0] val, input logic [cal_pkg::IDX_W-1:0] pos);
		list_result_t r;
		int j;
		r = '0;
		r.code = cal_pkg::ST_OK;
		case (op)
			cal_pkg::OP_APPEND: begin
				if (held_count >= cal_pkg::CAPACITY) begin
					r.code = cal_pkg::ST_FULL;
				end else begin
					slot_mem[cal_pkg::IDX_W'(held_count)] = val;
					held_count++;
				end
			end
			cal_pkg::OP_INSERT: begin
				// Shift everything from the cursor up, then drop the new entry under it.
				if (held_count >= cal_pkg::CAPACITY) begin
					r.code = cal_pkg::ST_FULL;
				end else begin
					for (j = held_count; j > cursor_pos; j--)
						slot_mem[cal_pkg::IDX_W'(j)] = slot_mem[cal_pkg::IDX_W'(j - 1)];
					slot_mem[cursor_pos] = val;
					held_count++;
				end
			end
			cal_pkg::OP_ERASE: begin
				// Close the gap, then pull the cursor back if it fell off the end.
				if (held_count == 0) begin
					r.code = cal_pkg::ST_EMPTY;
				end else begin
					r.read_val = slot_mem[cursor_pos];
					for (j = cursor_pos; j + 1 < held_count; j++)
						slot_mem[cal_pkg::IDX_W'(j)] = slot_mem[cal_pkg::IDX_W'(j + 1)];
					held_count--;
					if (held_count == 0)
						cursor_pos = '0;
					else if (cursor_pos >= held_count)
						cursor_pos = cal_pkg::IDX_W'(held_count - 1);
				end
			end
			cal_pkg::OP_SET: begin
				if (held_count == 0)
					r.code = cal_pkg::ST_EMPTY;
				else if (pos >= held_count)
					r.code = cal_pkg::ST_RANGE;
				else
					cursor_pos = pos;
			end
			cal_pkg::OP_BEGIN: begin
				cursor_pos = '0;
				if (held_count == 0)
					r.code = cal_pkg::ST_EMPTY;
			end
			cal_pkg::OP_END: begin
				if (held_count == 0) begin
					cursor_pos = '0;
					r.code = cal_pkg::ST_EMPTY;
				end else begin
					cursor_pos = cal_pkg::IDX_W'(held_count - 1);
				end
			end
			cal_pkg::OP_PREV: begin
				if (held_count == 0)
					r.code = cal_pkg::ST_EMPTY;
				else if (cursor_pos != 0)
					cursor_pos--;
			end
			cal_pkg::OP_NEXT: begin
				if (held_count == 0)
					r.code = cal_pkg::ST_EMPTY;
				else if (cursor_pos + 1 < held_count)
					cursor_pos++;
			end
			cal_pkg::OP_CLEAR: begin
				held_count = '0;
				cursor_pos = '0;
			end
			cal_pkg::OP_FIND: begin
				// Stop at the first match; the last entry is searched too.
				if (held_count == 0) begin
					r.code = cal_pkg::ST_EMPTY;
				end else begin
					r.code = cal_pkg::ST_NOTFOUND;
					for (j = 0; j < held_count && r.code == cal_pkg::ST_NOTFOUND; j++) begin
						if (slot_mem[cal_pkg::IDX_W'(j)] == val) begin
							r.match_idx = cal_pkg::IDX_W'(j);
							r.code = cal_pkg::ST_OK;
						end
					end
				end
			end
			cal_pkg::OP_READ: begin
				if (held_count == 0)
					r.code = cal_pkg::ST_EMPTY;
				else
					r.read_val = slot_mem[cursor_pos];
			end
			default: ;
		endcase
		r.cur_pos = cursor_pos;
		r.entries_held = held_count;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input list_result_t want,
			input list_result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%s: want rd=%h idx=%0d cur=%0d size=%0d st=%0d, %s",
				what, want.read_val, want.match_idx, want.cur_pos, want.entries_held,
				want.code,
				$sformatf("got rd=%h idx=%0d cur=%0d size=%0d st=%0d",
					got.read_val, got.match_idx, got.cur_pos, got.entries_held,
					got.code));
	endtask

	// Everything is sampled at the rising edge, before the block's own updates land:
	// retire results against the oldest expectation, model newly accepted items,
	// and keep the watchdog fed while anything moves.
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n) begin
			if (done) begin
				got = {read_value, found_index, cursor_now, list_size, status};
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want)
						report_mismatch("result mismatch", want, got);
				end
			end
			if (start && !busy) begin
				want = apply_list_op(operation, value, position);
				if (known_valid)
					want = known_result;
				pending_results.push_back(want);
			end
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Offer one item and hold it until the block takes it. Idle first with the given
	// odds in percent, scrambling the payload so a low start must really gate it.
	task automatic issue_item(input logic [3:0] op, input logic [cal_pkg::DATA_W-1:0] val,
			input logic [cal_pkg::IDX_W-1:0] pos, input logic known, input list_result_t res,
			input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			value <= $urandom;
			position <= cal_pkg::IDX_W'($urandom_range(cal_pkg::CAPACITY - 1));
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		value <= val;
		position <= pos;
		known_valid <= known;
		known_result <= res;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Pick an operation weighted so the list wanders between empty and full, with
	// searches usually aimed at something recently stored.
	task automatic issue_random(input int idle_pct);
		int pick;
		logic [3:0] op;
		logic [cal_pkg::DATA_W-1:0] val;
		pick = $urandom_range(99);
		if (pick < 20)
			op = cal_pkg::OP_APPEND;
		else if (pick < 36)
			op = cal_pkg::OP_INSERT;
		else if (pick < 48)
			op = cal_pkg::OP_ERASE;
		else if (pick < 56)
			op = cal_pkg::OP_SET;
		else if (pick < 59)
			op = cal_pkg::OP_BEGIN;
		else if (pick < 62)
			op = cal_pkg::OP_END;
		else if (pick < 68)
			op = cal_pkg::OP_PREV;
		else if (pick < 74)
			op = cal_pkg::OP_NEXT;
		else if (pick < 75)
			op = cal_pkg::OP_CLEAR;
		else if (pick < 87)
			op = cal_pkg::OP_FIND;
		else if (pick < 97)
			op = cal_pkg::OP_READ;
		else
			op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
		if (op == cal_pkg::OP_FIND && $urandom_range(3) != 0)
			val = value_pool[3'($urandom_range(7))];
		else if ($urandom_range(3) == 0)
			val = cal_pkg::DATA_W'($urandom_range(7));
		else
			val = $urandom;
		if (op == cal_pkg::OP_APPEND || op == cal_pkg::OP_INSERT)
			value_pool[3'($urandom_range(7))] = val;
		issue_item(op, val, cal_pkg::IDX_W'($urandom_range(cal_pkg::CAPACITY - 1)), 1'b0, '0,
			idle_pct);
	endtask

	// Drop start and wait until every owed result has come back.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	initial begin
		int i;
		int k;
		for (i = 0; i < cal_pkg::CAPACITY; i++)
			slot_mem[i] = '0;
		for (i = 0; i < 8; i++)
			value_pool[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed script, sender idling now and then.
		for (i = 0; i < SCRIPT_LEN; i++)
			for (k = 0; k < script[i].reps; k++)
				issue_item(script[i].op, script[i].val, script[i].pos, script[i].known,
					script[i].res, 20);

		// Random phases: light sender gaps, heavy gaps, then back to back.
		// Let the block run dry between phases.
		for (i = 0; i < 270; i++)
			issue_random(20);
		drain_results();
		for (i = 0; i < 270; i++)
			issue_random(48);
		drain_results();
		for (i = 0; i < 260; i++)
			issue_random(0);
		drain_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- cursor_array_list.f -----
sv/cal_pkg.sv
sv/cal_cell.sv
sv/cursor_array_list.sv
bench/tb_cursor_array_list.sv
